>>> hw/rtl/mau_pkg.sv
// Shared constants, command codes and control types of the modular arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package mau_pkg;

   localparam longint unsigned MAU_MODULUS  = 64'd1000000007;
   localparam int              MAU_EXP_BITS = 30;

   localparam int DATA_W = 30;  // width of residue and exponent fields on the ports
   localparam int CMD_W  = 3;
   localparam int RED_LAT = 3;  // input reduction pipeline depth
   localparam int MM_LAT  = 4;  // modular multiplier pipeline depth

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_POW = 3'd4,
      CMD_CMP = 3'd5
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } ctl_type;

endpackage
`default_nettype wire

>>> hw/rtl/mau_reduce.sv
// Three-stage reduction of a port word modulo the modulus (reciprocal multiply).
`timescale 1ns / 1ps
`default_nettype none
module mau_reduce #(
   parameter longint unsigned MODULUS = mau_pkg::MAU_MODULUS,
   parameter int              RES_W   = 30
) (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic [mau_pkg::DATA_W-1:0] x,
   output logic      [RES_W-1:0]           r
);
   import mau_pkg::*;

   localparam int SH   = DATA_W + RES_W;
   localparam longint unsigned MU = (64'd1 << SH) / MODULUS;
   localparam int Q_W  = (DATA_W + 2 > RES_W) ? DATA_W + 2 - RES_W : 1;
   localparam int PR_W = SH + Q_W;
   localparam int QM_W = Q_W + RES_W;
   localparam int T_W  = RES_W + 1;
   localparam logic [T_W-1:0] M_T = T_W'(MODULUS);

   logic [PR_W-1:0]   prod;
   logic [QM_W-1:0]   qm;
   logic [Q_W-1:0]    q_ff;
   logic [DATA_W-1:0] x_ff;
   logic [T_W-1:0]    t_ff;
   logic [RES_W-1:0]  r_ff;

   always_comb begin
      prod = PR_W'(x) * PR_W'(MU);
      qm   = QM_W'(q_ff) * QM_W'(MODULUS);
   end

   // quotient estimate is at most one short, so one correction suffices
   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= prod[SH +: Q_W];
         x_ff <= x;
         t_ff <= T_W'(x_ff) - qm[T_W-1:0];
         r_ff <= (t_ff >= M_T) ? RES_W'(t_ff - M_T) : RES_W'(t_ff);
      end
   end

   assign r = r_ff;

endmodule
`default_nettype wire

>>> hw/rtl/mau_modmul.sv
// Four-stage Barrett modular multiplier for residues below the modulus.
`timescale 1ns / 1ps
`default_nettype none
module mau_modmul #(
   parameter longint unsigned MODULUS = mau_pkg::MAU_MODULUS,
   parameter int              RES_W   = 30
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [RES_W-1:0] x,
   input  wire logic [RES_W-1:0] y,
   output logic      [RES_W-1:0] p
);
   import mau_pkg::*;

   localparam int P_W  = 2 * RES_W;
   localparam longint unsigned MU = (64'd1 << P_W) / MODULUS;
   localparam int MU_W = RES_W + 2;
   localparam int Q_W  = RES_W + 2;
   localparam int R_W  = RES_W + 2;
   localparam int QP_W = RES_W + 1 + MU_W;
   localparam int QM_W = Q_W + RES_W;
   localparam logic [R_W-1:0] M1 = R_W'(MODULUS);
   localparam logic [R_W-1:0] M2 = R_W'(2 * MODULUS);

   logic [P_W-1:0]   p_ff;
   logic [QP_W-1:0]  qp;
   logic [Q_W-1:0]   q_ff;
   logic [R_W-1:0]   plo_ff;
   logic [QM_W-1:0]  qm;
   logic [R_W-1:0]   r_ff;
   logic [RES_W-1:0] out_ff;

   always_comb begin
      qp = QP_W'(p_ff[P_W-1:RES_W-1]) * QP_W'(MU);
      qm = QM_W'(q_ff) * QM_W'(MODULUS);
   end

   // remainder estimate lands below 3M
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= P_W'(x) * P_W'(y);
         q_ff   <= qp[RES_W+1 +: Q_W];
         plo_ff <= p_ff[R_W-1:0];
         r_ff   <= plo_ff - qm[R_W-1:0];
         if (r_ff >= M2) begin
            out_ff <= RES_W'(r_ff - M2);
         end else if (r_ff >= M1) begin
            out_ff <= RES_W'(r_ff - M1);
         end else begin
            out_ff <= RES_W'(r_ff);
         end
      end
   end

   assign p = out_ff;

endmodule
`default_nettype wire

>>> hw/rtl/mau_cell.sv
// One square-and-multiply cell: consumes the low exponent bit and passes the word on.
`timescale 1ns / 1ps
`default_nettype none
module mau_cell #(
   parameter longint unsigned MODULUS = mau_pkg::MAU_MODULUS,
   parameter int              RES_W   = 30,
   parameter int              EXP_W   = 30
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire mau_pkg::ctl_type ctl_in,
   input  wire logic [RES_W-1:0] a_in,
   input  wire logic [RES_W-1:0] b_in,
   input  wire logic [RES_W-1:0] acc_in,
   input  wire logic [RES_W-1:0] sq_in,
   input  wire logic [EXP_W-1:0] exp_in,
   output mau_pkg::ctl_type      ctl_out,
   output logic      [RES_W-1:0] a_out,
   output logic      [RES_W-1:0] b_out,
   output logic      [RES_W-1:0] acc_out,
   output logic      [RES_W-1:0] sq_out,
   output logic      [EXP_W-1:0] exp_out
);
   import mau_pkg::*;

   ctl_type          ctl_ff [MM_LAT];
   logic [RES_W-1:0] a_ff   [MM_LAT];
   logic [RES_W-1:0] b_ff   [MM_LAT];
   logic [RES_W-1:0] acc_ff [MM_LAT];
   logic [EXP_W-1:0] exp_ff [MM_LAT];
   logic             bit_ff [MM_LAT];
   logic [RES_W-1:0] acc_prod;

   mau_modmul #(.MODULUS(MODULUS), .RES_W(RES_W)) u_mul (
      .clock(clock), .en(en), .x(acc_in), .y(sq_in), .p(acc_prod)
   );

   mau_modmul #(.MODULUS(MODULUS), .RES_W(RES_W)) u_sqr (
      .clock(clock), .en(en), .x(sq_in), .y(sq_in), .p(sq_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MM_LAT; i++) begin
            ctl_ff[i] <= '0;
         end
      end else if (en) begin
         ctl_ff[0] <= ctl_in;
         for (int i = 1; i < MM_LAT; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   // side data rides alongside the multipliers
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0]   <= a_in;
         b_ff[0]   <= b_in;
         acc_ff[0] <= acc_in;
         exp_ff[0] <= {1'b0, exp_in[EXP_W-1:1]};
         bit_ff[0] <= exp_in[0];
         for (int i = 1; i < MM_LAT; i++) begin
            a_ff[i]   <= a_ff[i-1];
            b_ff[i]   <= b_ff[i-1];
            acc_ff[i] <= acc_ff[i-1];
            exp_ff[i] <= exp_ff[i-1];
            bit_ff[i] <= bit_ff[i-1];
         end
      end
   end

   assign ctl_out = ctl_ff[MM_LAT-1];
   assign a_out   = a_ff[MM_LAT-1];
   assign b_out   = b_ff[MM_LAT-1];
   assign exp_out = exp_ff[MM_LAT-1];
   assign acc_out = bit_ff[MM_LAT-1] ? acc_prod : acc_ff[MM_LAT-1];

endmodule
`default_nettype wire

>>> hw/rtl/modular_arithmetic_unit_core.sv
// Top level of the modular arithmetic unit: reduction, square-and-multiply chain, finish.
`timescale 1ns / 1ps
`default_nettype none
// Modular ALU over a prime modulus (default 1000000007). Each request word carries a
// command (add, subtract, multiply, divide, power, compare), two residues and an exponent,
// and yields exactly one response word, in order. Operands are first reduced modulo the
// modulus. Power, multiply and divide all run through one chain of square-and-multiply
// cells, one cell per exponent bit: power uses the exponent, multiply uses exponent 1 on
// operand b, divide raises b to modulus-2 (Fermat inverse) and the tail multiplier then
// applies operand a. Divide by zero gives value 0 with div_error set; commands 6 and 7
// return all zeros. The pipeline takes one word per clock while req_stall is low. Words pass
// through the reduction stages, the cell chain (as many cells as the larger of EXP_BITS and
// the modulus width, each with four-stage multipliers), the tail multiplier and the response
// register. The pipeline only holds when the response register is full, stalled and the
// last stage carries a word, so bubbles are squeezed out.
module modular_arithmetic_unit_core #(
   parameter longint unsigned MODULUS  = mau_pkg::MAU_MODULUS,
   parameter int              EXP_BITS = mau_pkg::MAU_EXP_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [mau_pkg::CMD_W-1:0]  req_command,
   input  wire logic [mau_pkg::DATA_W-1:0] req_operand_a,
   input  wire logic [mau_pkg::DATA_W-1:0] req_operand_b,
   input  wire logic [mau_pkg::DATA_W-1:0] req_exponent,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [mau_pkg::DATA_W-1:0] rsp_value,
   output logic                            rsp_is_less,
   output logic                            rsp_is_equal,
   output logic                            rsp_is_greater,
   output logic                            rsp_div_error
);
   import mau_pkg::*;

   localparam int RES_W = $clog2(MODULUS + 1);
   localparam int EW    = (EXP_BITS > RES_W) ? EXP_BITS : RES_W;
   localparam logic [DATA_W-1:0] EXP_MASK = DATA_W'((64'd1 << EXP_BITS) - 64'd1);
   localparam logic [EW-1:0]     EXP_INV  = EW'(MODULUS - 2);
   localparam logic [RES_W-1:0]  ONE      = RES_W'(1);
   localparam logic [RES_W:0]    M_S      = (RES_W + 1)'(MODULUS);

   // global advance: hold only when the tail word has nowhere to go
   logic en;

   // front: operand reduction with command and exponent alongside
   ctl_type           front_ctl_ff [RED_LAT];
   logic [EW-1:0]     front_exp_ff [RED_LAT];
   logic [RES_W-1:0]  a_red;
   logic [RES_W-1:0]  b_red;

   // cell chain links
   ctl_type           ch_ctl [EW+1];
   logic [RES_W-1:0]  ch_a   [EW+1];
   logic [RES_W-1:0]  ch_b   [EW+1];
   logic [RES_W-1:0]  ch_acc [EW+1];
   logic [RES_W-1:0]  ch_sq  [EW+1];
   logic [EW-1:0]     ch_exp [EW+1];

   // tail: final multiply by operand a for multiply and divide, by one otherwise
   logic [RES_W-1:0]  mul_by;
   logic [RES_W-1:0]  fin_prod;
   ctl_type           tail_ctl_ff [MM_LAT];
   logic [RES_W-1:0]  tail_a_ff   [MM_LAT];
   logic [RES_W-1:0]  tail_b_ff   [MM_LAT];
   ctl_type           tail_ctl;
   logic [RES_W-1:0]  ta;
   logic [RES_W-1:0]  tb;

   // finish and response register
   logic [RES_W:0]    sum;
   logic [RES_W:0]    val;
   logic              lt_in, eq_in, gt_in, err_in;
   logic                 rsp_valid_ff;
   logic [DATA_W-1:0]    rsp_value_ff;
   logic                 rsp_less_ff, rsp_equal_ff, rsp_greater_ff, rsp_err_ff;

   assign tail_ctl = tail_ctl_ff[MM_LAT-1];
   assign ta       = tail_a_ff[MM_LAT-1];
   assign tb       = tail_b_ff[MM_LAT-1];
   assign en        = !(rsp_valid_ff && rsp_stall && tail_ctl.valid);
   assign req_stall = !en;

   // ---------------- front ----------------
   mau_reduce #(.MODULUS(MODULUS), .RES_W(RES_W)) u_red_a (
      .clock(clock), .en(en), .x(req_operand_a), .r(a_red)
   );

   mau_reduce #(.MODULUS(MODULUS), .RES_W(RES_W)) u_red_b (
      .clock(clock), .en(en), .x(req_operand_b), .r(b_red)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RED_LAT; i++) begin
            front_ctl_ff[i] <= '0;
         end
      end else if (en) begin
         front_ctl_ff[0] <= '{valid: req_valid, cmd: cmd_type'(req_command)};
         for (int i = 1; i < RED_LAT; i++) begin
            front_ctl_ff[i] <= front_ctl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         front_exp_ff[0] <= EW'(req_exponent & EXP_MASK);
         for (int i = 1; i < RED_LAT; i++) begin
            front_exp_ff[i] <= front_exp_ff[i-1];
         end
      end
   end

   // chain set-up: pick base and exponent per command
   always_comb begin
      ch_ctl[0] = front_ctl_ff[RED_LAT-1];
      ch_a[0]   = a_red;
      ch_b[0]   = b_red;
      ch_acc[0] = ONE;
      ch_sq[0]  = b_red;
      ch_exp[0] = '0;
      case (front_ctl_ff[RED_LAT-1].cmd)
         CMD_POW: begin
            ch_sq[0]  = a_red;
            ch_exp[0] = front_exp_ff[RED_LAT-1];
         end
         CMD_DIV: ch_exp[0] = EXP_INV;
         CMD_MUL: ch_exp[0] = EW'(1);
         default: ch_exp[0] = '0;
      endcase
   end

   // ---------------- square-and-multiply chain ----------------
   for (genvar g = 0; g < EW; g++) begin : g_cell
      mau_cell #(.MODULUS(MODULUS), .RES_W(RES_W), .EXP_W(EW)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .ctl_in (ch_ctl[g]),
         .a_in   (ch_a[g]),
         .b_in   (ch_b[g]),
         .acc_in (ch_acc[g]),
         .sq_in  (ch_sq[g]),
         .exp_in (ch_exp[g]),
         .ctl_out(ch_ctl[g+1]),
         .a_out  (ch_a[g+1]),
         .b_out  (ch_b[g+1]),
         .acc_out(ch_acc[g+1]),
         .sq_out (ch_sq[g+1]),
         .exp_out(ch_exp[g+1])
      );
   end

   // ---------------- tail multiply ----------------
   always_comb begin
      mul_by = ONE;
      case (ch_ctl[EW].cmd)
         CMD_MUL, CMD_DIV: mul_by = ch_a[EW];
         default:          mul_by = ONE;
      endcase
   end

   mau_modmul #(.MODULUS(MODULUS), .RES_W(RES_W)) u_fin (
      .clock(clock), .en(en), .x(ch_acc[EW]), .y(mul_by), .p(fin_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MM_LAT; i++) begin
            tail_ctl_ff[i] <= '0;
         end
      end else if (en) begin
         tail_ctl_ff[0] <= ch_ctl[EW];
         for (int i = 1; i < MM_LAT; i++) begin
            tail_ctl_ff[i] <= tail_ctl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tail_a_ff[0] <= ch_a[EW];
         tail_b_ff[0] <= ch_b[EW];
         for (int i = 1; i < MM_LAT; i++) begin
            tail_a_ff[i] <= tail_a_ff[i-1];
            tail_b_ff[i] <= tail_b_ff[i-1];
         end
      end
   end

   // ---------------- finish ----------------
   always_comb begin
      sum    = '0;
      val    = '0;
      lt_in  = 1'b0;
      eq_in  = 1'b0;
      gt_in  = 1'b0;
      err_in = 1'b0;
      unique case (tail_ctl.cmd)
         CMD_ADD: begin
            sum = (RES_W + 1)'(ta) + (RES_W + 1)'(tb);
            val = (sum >= M_S) ? sum - M_S : sum;
         end
         CMD_SUB: begin
            if (ta >= tb) begin
               val = (RES_W + 1)'(ta) - (RES_W + 1)'(tb);
            end else begin
               val = (RES_W + 1)'(ta) + M_S - (RES_W + 1)'(tb);
            end
         end
         CMD_MUL, CMD_POW: val = (RES_W + 1)'(fin_prod);
         CMD_DIV: begin
            // zero divisor: the inverse chain already yields 0, flag it
            err_in = (tb == '0);
            val    = err_in ? '0 : (RES_W + 1)'(fin_prod);
         end
         CMD_CMP: begin
            lt_in = (ta < tb);
            eq_in = (ta == tb);
            gt_in = (ta > tb);
         end
         default: val = '0;
      endcase
   end

   // response register parts the pipeline from the consumer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en && tail_ctl.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en && tail_ctl.valid) begin
         rsp_value_ff   <= DATA_W'(val);
         rsp_less_ff    <= lt_in;
         rsp_equal_ff   <= eq_in;
         rsp_greater_ff <= gt_in;
         rsp_err_ff     <= err_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_is_less    = rsp_less_ff;
   assign rsp_is_equal   = rsp_equal_ff;
   assign rsp_is_greater = rsp_greater_ff;
   assign rsp_div_error  = rsp_err_ff;

endmodule
`default_nettype wire
